### hw/rtl/process_image_range_table_macros.svh
// Assertion macros used by the checker file of the image range table.
`ifndef PROCESS_IMAGE_RANGE_TABLE_MACROS_SVH
`define PROCESS_IMAGE_RANGE_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define AST_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define AST_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/pirt_pkg.sv
// Package of the image range table: widths, codes and the types passed along the cell row.
package pirt_pkg;

	localparam int ENTRIES_DEF = 16;

	localparam int CMD_W  = 2;
	localparam int PID_W  = 32;
	localparam int ADDR_W = 64;
	localparam int SIZE_W = 32;
	localparam int TAG_W  = 16;
	localparam int STAT_W = 2;

	localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_UNLOAD = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic              vld;
		logic [CMD_W-1:0]  cmd;
		logic [PID_W-1:0]  pid;
		logic [ADDR_W-1:0] addr;
		logic              match;
		logic              free;
		logic              best_hit;
		logic [ADDR_W-1:0] best_base;
		logic [SIZE_W-1:0] best_size;
		logic [TAG_W-1:0]  best_tag;
	} token_t;

	typedef struct packed {
		logic              load;
		logic              unload;
		logic              any_match;
		logic [PID_W-1:0]  pid;
		logic [ADDR_W-1:0] base;
		logic [SIZE_W-1:0] size;
		logic [TAG_W-1:0]  tag;
	} commit_t;

endpackage

### hw/rtl/pirt_if.sv
// Valid/ready channel interfaces for commands and results of the image range table.
interface pirt_req_if;
	logic                         valid;
	logic                         ready;
	logic [pirt_pkg::CMD_W-1:0]   cmd;
	logic [pirt_pkg::PID_W-1:0]   process_id;
	logic [pirt_pkg::ADDR_W-1:0]  address;
	logic [pirt_pkg::SIZE_W-1:0]  image_size;
	logic [pirt_pkg::TAG_W-1:0]   image_tag;

	modport source (output valid, cmd, process_id, address, image_size, image_tag,
		input ready);
	modport sink (input valid, cmd, process_id, address, image_size, image_tag,
		output ready);
endinterface

interface pirt_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [pirt_pkg::STAT_W-1:0]  status;
	logic [pirt_pkg::ADDR_W-1:0]  found_base;
	logic [pirt_pkg::TAG_W-1:0]   found_tag;

	modport source (output valid, status, found_base, found_tag, input ready);
	modport sink (input valid, status, found_base, found_tag, output ready);
endinterface

### hw/rtl/process_image_range_table.sv
// Top level of the image range table: command control, row of entry cells, result register.
// Path: a command walks the cell row through each cell's register, then fin_q, then the result register.
// A new command is taken once the previous one has left the row and updated the table.
// Reset: arst_n clears all entry valid bits, the row, the control state and the result valid.
module process_image_range_table #(
	parameter int ENTRIES = pirt_pkg::ENTRIES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	pirt_req_if.sink   req,
	pirt_rsp_if.source rsp
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0]                    state_q;
	logic                          acc;
	logic                          emit;
	pirt_pkg::token_t              tok [ENTRIES+1];
	pirt_pkg::token_t              fin_q;
	pirt_pkg::commit_t             commit;
	logic [pirt_pkg::SIZE_W-1:0]   size_q;
	logic [pirt_pkg::TAG_W-1:0]    tag_q;
	logic                          rsp_vld_q;
	logic [pirt_pkg::STAT_W-1:0]   status_q;
	logic [pirt_pkg::ADDR_W-1:0]   base_q;
	logic [pirt_pkg::TAG_W-1:0]    ftag_q;
	logic [pirt_pkg::ADDR_W-1:0]   offs;
	logic                          in_range;
	logic [pirt_pkg::STAT_W-1:0]   status_d;
	logic                          find_hit;

	assign req.ready = (state_q == S_IDLE);
	assign acc       = req.valid && req.ready;
	assign emit      = (state_q == S_DONE) && (!rsp_vld_q || rsp.ready);

	always_comb begin
		tok[0]           = '0;
		tok[0].vld       = acc;
		tok[0].cmd       = req.cmd;
		tok[0].pid       = req.process_id;
		tok[0].addr      = req.address;
	end

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		pirt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.prev   (tok[i]),
			.next   (tok[i+1]),
			.commit (commit)
		);
	end

	always_comb begin
		offs     = fin_q.addr - fin_q.best_base;
		in_range = offs < {{(pirt_pkg::ADDR_W-pirt_pkg::SIZE_W){1'b0}}, fin_q.best_size};
		find_hit = 1'b0;
		unique case (fin_q.cmd)
			pirt_pkg::CMD_LOAD: begin
				status_d = (fin_q.match || fin_q.free) ? pirt_pkg::ST_OK : pirt_pkg::ST_FULL;
			end
			pirt_pkg::CMD_UNLOAD: begin
				status_d = fin_q.match ? pirt_pkg::ST_OK : pirt_pkg::ST_MISS;
			end
			pirt_pkg::CMD_FIND: begin
				find_hit = fin_q.best_hit && in_range;
				status_d = find_hit ? pirt_pkg::ST_OK : pirt_pkg::ST_MISS;
			end
			default: begin
				status_d = pirt_pkg::ST_MISS;
			end
		endcase
	end

	always_comb begin
		commit.load      = emit && (fin_q.cmd == pirt_pkg::CMD_LOAD);
		commit.unload    = emit && (fin_q.cmd == pirt_pkg::CMD_UNLOAD);
		commit.any_match = fin_q.match;
		commit.pid       = fin_q.pid;
		commit.base      = fin_q.addr;
		commit.size      = size_q;
		commit.tag       = tag_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rsp_vld_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (tok[ENTRIES].vld) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (emit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (emit) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			size_q <= req.image_size;
			tag_q  <= req.image_tag;
		end
		if (state_q == S_SCAN && tok[ENTRIES].vld) begin
			fin_q <= tok[ENTRIES];
		end
		if (emit) begin
			status_q <= status_d;
			base_q   <= find_hit ? fin_q.best_base : '0;
			ftag_q   <= find_hit ? fin_q.best_tag : '0;
		end
	end

	assign rsp.valid      = rsp_vld_q;
	assign rsp.status     = status_q;
	assign rsp.found_base = base_q;
	assign rsp.found_tag  = ftag_q;

endmodule

### hw/rtl/pirt_cell.sv
// One table cell: holds one image entry, updates the passing scan item and applies commits.
module pirt_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  pirt_pkg::token_t  prev,
	output pirt_pkg::token_t  next,
	input  pirt_pkg::commit_t commit
);

	logic                          valid_q;
	logic [pirt_pkg::PID_W-1:0]    pid_q;
	logic [pirt_pkg::ADDR_W-1:0]   base_q;
	logic [pirt_pkg::SIZE_W-1:0]   size_q;
	logic [pirt_pkg::TAG_W-1:0]    tag_q;
	logic                          match_q;
	logic                          free_q;
	logic                          tok_vld_q;
	pirt_pkg::token_t              tok_q;
	pirt_pkg::token_t              upd;
	logic                          pid_hit;
	logic                          key_hit;
	logic                          cand;
	logic                          wr;

	always_comb begin
		pid_hit = valid_q && (pid_q == prev.pid);
		key_hit = pid_hit && (base_q == prev.addr);
		cand    = pid_hit && (base_q <= prev.addr) && (!prev.best_hit || base_q > prev.best_base);
		upd       = prev;
		upd.match = prev.match | key_hit;
		upd.free  = prev.free | !valid_q;
		if (cand) begin
			upd.best_hit  = 1'b1;
			upd.best_base = base_q;
			upd.best_size = size_q;
			upd.best_tag  = tag_q;
		end
	end

	assign wr = commit.load && (match_q || (!commit.any_match && free_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			match_q   <= 1'b0;
			free_q    <= 1'b0;
			tok_vld_q <= 1'b0;
		end else begin
			tok_vld_q <= prev.vld;
			if (prev.vld) begin
				match_q <= key_hit && !prev.match;
				free_q  <= !valid_q && !prev.free;
			end
			if (wr) begin
				valid_q <= 1'b1;
			end else if (commit.unload && match_q) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (prev.vld) begin
			tok_q <= upd;
		end
		if (wr) begin
			pid_q  <= commit.pid;
			base_q <= commit.base;
			size_q <= commit.size;
			tag_q  <= commit.tag;
		end
	end

	always_comb begin
		next     = tok_q;
		next.vld = tok_vld_q;
	end

endmodule

### hw/rtl/pirt_checker.sv
// Port-level checks of the image range table and their binding to the top level.
`include "process_image_range_table_macros.svh"

module pirt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [pirt_pkg::STAT_W-1:0]   status,
	input logic [pirt_pkg::ADDR_W-1:0]   found_base,
	input logic [pirt_pkg::TAG_W-1:0]    found_tag
);

	logic code_known;
	logic payload_zero;

	assign code_known   = (status == pirt_pkg::ST_OK) || (status == pirt_pkg::ST_MISS)
		|| (status == pirt_pkg::ST_FULL);
	assign payload_zero = (found_base == '0) && (found_tag == '0);

	`AST_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "ready held after accept")
	`AST_IMPL(a_status_code, rsp_valid, code_known, "unused status code")
	`AST_IMPL(a_zero_on_miss, rsp_valid && status != pirt_pkg::ST_OK, payload_zero, "payload")
	`AST_NEXT(a_hold_stalled, rsp_valid && !rsp_ready, rsp_valid && $stable({status, found_base, found_tag}), "stalled result changed")

endmodule

bind process_image_range_table pirt_checker u_pirt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.status     (rsp.status),
	.found_base (rsp.found_base),
	.found_tag  (rsp.found_tag)
);

### sim/process_image_range_table_test.sv
// Testbench of the image range table: directed rows, then random load, unload, find and spare-code items.
`timescale 1ns / 100ps

module process_image_range_table_test;
	import pirt_pkg::*;

	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
	localparam int SLOTS = ENTRIES_DEF;
	localparam int RANDOM_ITEMS = 650;
	localparam logic [ADDR_W-1:0] ADDR_TOP = {ADDR_W{1'b1}};

	typedef struct packed {
		logic [CMD_W-1:0]  op;
		logic [PID_W-1:0]  pid;
		logic [ADDR_W-1:0] addr;
		logic [SIZE_W-1:0] len;
		logic [TAG_W-1:0]  tag;
	} image_cmd_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [ADDR_W-1:0] base;
		logic [TAG_W-1:0]  tag;
	} image_reply_t;

	typedef struct packed {
		image_cmd_t   item;
		logic         typed;
		image_reply_t want;
	} plan_row_t;

	localparam image_reply_t R_OK   = '{ST_OK, 64'd0, 16'd0};
	localparam image_reply_t R_MISS = '{ST_MISS, 64'd0, 16'd0};
	localparam int PLAN_LEN = 22;
	localparam plan_row_t PLAN [PLAN_LEN] = '{
		'{'{CMD_FIND, 32'd0, 64'd0, 32'd0, 16'd0}, 1'b1, R_MISS},
		'{'{CMD_UNLOAD, 32'hFFFF_FFFF, ADDR_TOP, 32'd0, 16'd0}, 1'b1, R_MISS},
		'{'{CMD_SPARE, 32'hFFFF_FFFF, ADDR_TOP, 32'hFFFF_FFFF, 16'hFFFF}, 1'b1, R_MISS},
		'{'{CMD_LOAD, 32'd1, 64'h1000, 32'h100, 16'hAAAA}, 1'b1, R_OK},
		'{'{CMD_FIND, 32'd1, 64'h1000, 32'd0, 16'd0}, 1'b1, '{ST_OK, 64'h1000, 16'hAAAA}},
		'{'{CMD_FIND, 32'd1, 64'h10FF, 32'd0, 16'd0}, 1'b1, '{ST_OK, 64'h1000, 16'hAAAA}},
		'{'{CMD_FIND, 32'd1, 64'h1100, 32'd0, 16'd0}, 1'b1, R_MISS},
		'{'{CMD_FIND, 32'd1, 64'h0FFF, 32'd0, 16'd0}, 1'b1, R_MISS},
		'{'{CMD_FIND, 32'd2, 64'h1000, 32'd0, 16'd0}, 1'b1, R_MISS},
		'{'{CMD_LOAD, 32'd1, 64'h1080, 32'd0, 16'h5555}, 1'b1, R_OK},
		'{'{CMD_FIND, 32'd1, 64'h1090, 32'd0, 16'd0}, 1'b0, R_MISS},
		'{'{CMD_FIND, 32'd1, 64'h1010, 32'd0, 16'd0}, 1'b0, R_MISS},
		'{'{CMD_LOAD, 32'd1, 64'h1000, 32'h20, 16'h1234}, 1'b1, R_OK},
		'{'{CMD_FIND, 32'd1, 64'h1030, 32'd0, 16'd0}, 1'b0, R_MISS},
		'{'{CMD_FIND, 32'd1, 64'h101F, 32'd0, 16'd0}, 1'b0, R_MISS},
		'{'{CMD_LOAD, 32'hFFFF_FFFF, ADDR_TOP, 32'hFFFF_FFFF, 16'hFFFF}, 1'b1, R_OK},
		'{'{CMD_FIND, 32'hFFFF_FFFF, ADDR_TOP, 32'd0, 16'd0}, 1'b1,
			'{ST_OK, ADDR_TOP, 16'hFFFF}},
		'{'{CMD_LOAD, 32'd0, 64'd0, 32'd1, 16'd0}, 1'b1, R_OK},
		'{'{CMD_FIND, 32'd0, 64'd0, 32'd0, 16'd0}, 1'b1, '{ST_OK, 64'd0, 16'd0}},
		'{'{CMD_UNLOAD, 32'd1, 64'h1080, 32'd0, 16'd0}, 1'b1, R_OK},
		'{'{CMD_UNLOAD, 32'd1, 64'h1080, 32'd0, 16'd0}, 1'b1, R_MISS},
		'{'{CMD_FIND, 32'd1, 64'h1090, 32'd0, 16'd0}, 1'b0, R_MISS}
	};

	logic clk;
	logic arst_n;

	pirt_req_if req_ch();
	pirt_rsp_if rsp_ch();

	process_image_range_table dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	logic              img_valid [SLOTS];
	logic [PID_W-1:0]  img_pid   [SLOTS];
	logic [ADDR_W-1:0] img_base  [SLOTS];
	logic [SIZE_W-1:0] img_len   [SLOTS];
	logic [TAG_W-1:0]  img_tag   [SLOTS];

	image_reply_t image_replies [$];
	image_reply_t reply_want;
	int errors = 0;
	int reply_hold = 0;
	logic no_idle = 1'b0;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	initial begin
		#3_000_000;
		$display("process_image_range_table test failed");
		$finish;
	end

	function automatic int slot_of_key(logic [PID_W-1:0] pid, logic [ADDR_W-1:0] base);
		int slot;
		slot = -1;
		for (int i = 0; i < SLOTS; i++)
			if (slot < 0 && img_valid[i] && img_pid[i] == pid && img_base[i] == base)
				slot = i;
		return slot;
	endfunction

	function automatic image_reply_t lookup_image(image_cmd_t c);
		image_reply_t r;
		int slot;
		r = R_MISS;
		slot = -1;
		case (c.op)
		CMD_LOAD: begin
			slot = slot_of_key(c.pid, c.addr);
			for (int i = 0; i < SLOTS; i++)
				if (slot < 0 && !img_valid[i])
					slot = i;
			if (slot < 0) begin
				r.status = ST_FULL;
			end else begin
				img_valid[slot] = 1'b1;
				img_pid[slot] = c.pid;
				img_base[slot] = c.addr;
				img_len[slot] = c.len;
				img_tag[slot] = c.tag;
				r.status = ST_OK;
			end
		end
		CMD_UNLOAD: begin
			slot = slot_of_key(c.pid, c.addr);
			if (slot >= 0) begin
				img_valid[slot] = 1'b0;
				r.status = ST_OK;
			end
		end
		CMD_FIND: begin
			for (int i = 0; i < SLOTS; i++)
				if (img_valid[i] && img_pid[i] == c.pid && img_base[i] <= c.addr)
					if (slot < 0 || img_base[i] > img_base[slot])
						slot = i;
			if (slot >= 0 && (c.addr - img_base[slot]) < {32'd0, img_len[slot]}) begin
				r.status = ST_OK;
				r.base = img_base[slot];
				r.tag = img_tag[slot];
			end
		end
		default: ;
		endcase
		return r;
	endfunction

	function automatic int pick_loaded();
		int count;
		int pick;
		count = 0;
		for (int i = 0; i < SLOTS; i++)
			if (img_valid[i])
				count++;
		if (count == 0)
			return -1;
		pick = $urandom_range(0, count - 1);
		for (int i = 0; i < SLOTS; i++)
			if (img_valid[i]) begin
				if (pick == 0)
					return i;
				pick--;
			end
		return -1;
	endfunction

	function automatic logic [PID_W-1:0] pick_pid();
		case ($urandom_range(0, 5))
		0: return '0;
		1: return '1;
		5: return $urandom;
		default: return $urandom_range(1, 3);
		endcase
	endfunction

	function automatic logic [ADDR_W-1:0] pick_addr();
		case ($urandom_range(0, 5))
		0: return 64'd0;
		1: return ADDR_TOP - 64'($urandom_range(0, 3));
		4: return {$urandom, $urandom};
		5: return 64'hFFFF_FFFF_FFFF_F000 + 64'($urandom_range(0, 15)) * 64'h100;
		default: return 64'h1000 + 64'($urandom_range(0, 15)) * 64'h40;
		endcase
	endfunction

	function automatic logic [SIZE_W-1:0] pick_len();
		case ($urandom_range(0, 5))
		0: return '0;
		1: return '1;
		4: return $urandom_range(32'h40, 32'h400);
		5: return $urandom;
		default: return $urandom_range(1, 32'h80);
		endcase
	endfunction

	task automatic issue_cmd(input image_cmd_t c, input logic typed, input image_reply_t want);
		int gap;
		image_reply_t got;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.cmd <= c.op;
		req_ch.process_id <= c.pid;
		req_ch.address <= c.addr;
		req_ch.image_size <= c.len;
		req_ch.image_tag <= c.tag;
		do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
		got = lookup_image(c);
		image_replies.push_back(typed ? want : got);
	endtask

	always @(negedge clk) begin
		if (reply_hold != 0) begin
			rsp_ch.ready <= 1'b0;
			reply_hold = reply_hold - 1;
		end else begin
			rsp_ch.ready <= arst_n;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			reply_hold = no_idle ? 0 : $urandom_range(0, 9);
			if (image_replies.size() == 0) begin
				$error("unexpected item: status %0d base %h tag %h", rsp_ch.status,
					rsp_ch.found_base, rsp_ch.found_tag);
				errors++;
			end else begin
				reply_want = image_replies.pop_front();
				if (rsp_ch.status !== reply_want.status) begin
					$error("status: expected %0d, got %0d", reply_want.status, rsp_ch.status);
					errors++;
				end
				if (rsp_ch.found_base !== reply_want.base) begin
					$error("found_base: expected %h, got %h", reply_want.base,
						rsp_ch.found_base);
					errors++;
				end
				if (rsp_ch.found_tag !== reply_want.tag) begin
					$error("found_tag: expected %h, got %h", reply_want.tag, rsp_ch.found_tag);
					errors++;
				end
			end
		end
	end

	initial begin
		image_cmd_t c;
		int slot;
		int roll;
		int load_pct;
		logic [ADDR_W-1:0] span;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.cmd = CMD_LOAD;
		req_ch.process_id = '0;
		req_ch.address = '0;
		req_ch.image_size = '0;
		req_ch.image_tag = '0;
		rsp_ch.ready = 1'b0;
		load_pct = 50;
		for (int i = 0; i < SLOTS; i++) begin
			img_valid[i] = 1'b0;
			img_pid[i] = '0;
			img_base[i] = '0;
			img_len[i] = '0;
			img_tag[i] = '0;
		end
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		for (int k = 0; k < PLAN_LEN; k++)
			issue_cmd(PLAN[k].item, PLAN[k].typed, PLAN[k].want);

		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			if (k % 50 == 0) begin
				no_idle = (k != 0) && ($urandom_range(0, 3) == 0);
				load_pct = $urandom_range(10, 90);
			end
			roll = $urandom_range(0, 99);
			slot = pick_loaded();
			c.pid = pick_pid();
			c.addr = pick_addr();
			c.len = pick_len();
			c.tag = TAG_W'($urandom);
			if (k < 40) begin
				c.op = CMD_LOAD;
			end else if (roll < 4) begin
				c.op = CMD_SPARE;
				c.pid = $urandom;
				c.addr = {$urandom, $urandom};
			end else if (roll < 40) begin
				c.op = CMD_FIND;
				if (slot >= 0 && $urandom_range(0, 9) < 7) begin
					c.pid = img_pid[slot];
					span = {32'd0, img_len[slot]};
					case ($urandom_range(0, 4))
					0: c.addr = img_base[slot];
					1: c.addr = img_base[slot] + span - 1;
					2: c.addr = img_base[slot] + span;
					3: c.addr = img_base[slot] - 1;
					default: c.addr = img_base[slot] + ({$urandom, $urandom} % (span + 1));
					endcase
				end
			end else if ($urandom_range(0, 99) < load_pct) begin
				c.op = CMD_LOAD;
				if (slot >= 0 && $urandom_range(0, 3) == 0) begin
					c.pid = img_pid[slot];
					c.addr = img_base[slot];
				end
			end else begin
				c.op = CMD_UNLOAD;
				if (slot >= 0 && $urandom_range(0, 3) != 0) begin
					c.pid = img_pid[slot];
					c.addr = img_base[slot];
				end
			end
			issue_cmd(c, 1'b0, R_MISS);
		end

		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (image_replies.size() != 0)
			@(posedge clk);
		repeat (SLOTS + 12) @(posedge clk);
		if (errors == 0)
			$display("process_image_range_table test passed");
		else
			$display("process_image_range_table test failed");
		$finish;
	end
endmodule
